// ===== sv/mecodo_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the arctangent table for the odometry integrator
// no dependencies; imported by the controller, the datapath and the top level
package mecodo_pkg;

    // field and register widths
    localparam int CountW   = 16;
    localparam int SumW     = 18;
    localparam int GainW    = 24;
    localparam int PosW     = 48;
    localparam int HdgW     = 32;
    localparam int KindW    = 3;
    localparam int CfgIdxW  = 2;
    localparam int InDataW  = 72;
    localparam int OutDataW = 136;

    // datapath widths
    localparam int DistW  = 42;
    localparam int HalfW  = 21;
    localparam int TrigW  = 34;
    localparam int MagW   = 32;
    localparam int MulAW  = 24;
    localparam int ProdW  = MulAW + MagW;
    localparam int StepW  = 41;

    // cordic defaults
    localparam int CordicStepsDef = 20;
    localparam int CordicStepsMax = 30;
    localparam logic [TrigW-1:0] KinvQ30 = 34'd652032874;

    // register reset values
    localparam logic [GainW-1:0] ForwardGainRst = 24'd5211;
    localparam logic [GainW-1:0] StrafeGainRst  = 24'd3476;
    localparam logic [GainW-1:0] TurnGainRst    = 24'd1097871;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegMask    = 2'd0;
    localparam logic [CfgIdxW-1:0] RegForward = 2'd1;
    localparam logic [CfgIdxW-1:0] RegStrafe  = 2'd2;
    localparam logic [CfgIdxW-1:0] RegTurn    = 2'd3;

    // wheel direction codes
    localparam logic [1:0] SgnPos = 2'b01;
    localparam logic [1:0] SgnNeg = 2'b11;

    typedef enum logic [KindW-1:0] {
        KIND_NONE,
        KIND_FWD,
        KIND_BACK,
        KIND_LEFT,
        KIND_RIGHT,
        KIND_TURN_L,
        KIND_TURN_R
    } kind_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_DIST,
        DP_TURN,
        DP_ROT_INIT,
        DP_ROT_STEP,
        DP_MUL_LO,
        DP_MUL_HI,
        DP_APPLY
    } dp_op_t;

    // controller to datapath
    typedef struct packed {
        dp_op_t op;
        logic   axis;      // 0 x, 1 y
        logic   out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  rot_last;
        logic  out_busy;
    } dp_stat_t;

    // arctangent of 2^-i in 2^-32 turn units
    function automatic logic [29:0] atan_turns(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            5'd28:   v = 30'd3;
            5'd29:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/mecodo_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer for the odometry integrator: issues datapath commands per report
// depends on mecodo_pkg
module mecodo_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mecodo_pkg::dp_stat_t stat,
    output mecodo_pkg::dp_cmd_t  cmd
);
    import mecodo_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_TURN,
        ST_ROT_INIT,
        ST_ROT,
        ST_X_LO,
        ST_X_HI,
        ST_X_APP,
        ST_Y_LO,
        ST_Y_HI,
        ST_Y_APP,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_DIST;
            end
            ST_DIST:
            begin
                unique case (stat.kind)
                    KIND_TURN_L, KIND_TURN_R:               state_next = ST_TURN;
                    KIND_FWD, KIND_BACK, KIND_LEFT, KIND_RIGHT: state_next = ST_ROT_INIT;
                    default:                                state_next = ST_DONE;
                endcase
            end
            ST_TURN:     state_next = ST_DONE;
            ST_ROT_INIT: state_next = ST_ROT;
            ST_ROT:
            begin
                if (stat.rot_last)
                    state_next = ST_X_LO;
            end
            ST_X_LO:  state_next = ST_X_HI;
            ST_X_HI:  state_next = ST_X_APP;
            ST_X_APP: state_next = ST_Y_LO;
            ST_Y_LO:  state_next = ST_Y_HI;
            ST_Y_HI:  state_next = ST_Y_APP;
            ST_Y_APP: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!stat.out_busy)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // command decode
    always_comb
    begin
        cmd          = '0;
        cmd.op       = DP_NOP;
        unique case (state_reg)
            ST_IDLE:     cmd.op = s_tvalid ? DP_LOAD : DP_NOP;
            ST_DIST:     cmd.op = DP_DIST;
            ST_TURN:     cmd.op = DP_TURN;
            ST_ROT_INIT: cmd.op = DP_ROT_INIT;
            ST_ROT:      cmd.op = DP_ROT_STEP;
            ST_X_LO:     cmd.op = DP_MUL_LO;
            ST_X_HI:     cmd.op = DP_MUL_HI;
            ST_X_APP:    cmd.op = DP_APPLY;
            ST_Y_LO:
            begin
                cmd.op   = DP_MUL_LO;
                cmd.axis = 1'b1;
            end
            ST_Y_HI:
            begin
                cmd.op   = DP_MUL_HI;
                cmd.axis = 1'b1;
            end
            ST_Y_APP:
            begin
                cmd.op   = DP_APPLY;
                cmd.axis = 1'b1;
            end
            ST_DONE:     cmd.out_load = !stat.out_busy;
            default:     cmd.op = DP_NOP;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ===== sv/mecodo_dp.sv =====
`timescale 1ns / 1ps
// datapath: count sum, shared multiplier, iterative cordic, pose and result registers
// depends on mecodo_pkg; driven by mecodo_ctrl
module mecodo_dp #(
    parameter int CORDIC_STEPS = mecodo_pkg::CordicStepsDef
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [mecodo_pkg::InDataW-1:0]         in_data,
    input  logic                                   cfg_we,
    input  logic [mecodo_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [mecodo_pkg::GainW-1:0]           cfg_data,
    input  mecodo_pkg::dp_cmd_t                    cmd,
    output mecodo_pkg::dp_stat_t                   stat,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [mecodo_pkg::OutDataW-1:0]        out_data
);
    import mecodo_pkg::*;

    localparam int IterW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [IterW-1:0] IterLast = IterW'(CORDIC_STEPS - 1);

    // configuration registers
    logic             mask_reg;
    logic [GainW-1:0] fwd_gain_reg;
    logic [GainW-1:0] str_gain_reg;
    logic [GainW-1:0] turn_gain_reg;

    // pose and working registers
    logic [PosW-1:0]          x_reg;
    logic [PosW-1:0]          y_reg;
    logic [HdgW-1:0]          hdg_reg;
    logic [SumW-1:0]          sum_reg;
    kind_t                    kind_reg;
    logic [ProdW-1:0]         prod_reg;
    logic [ProdW-1:0]         acc_reg;
    logic [DistW-1:0]         dist_reg;
    logic signed [TrigW-1:0]  cx_reg;
    logic signed [TrigW-1:0]  cy_reg;
    logic signed [TrigW-1:0]  z_reg;
    logic                     flip_reg;
    logic [IterW-1:0]         iter_reg;
    logic                     out_valid_reg;
    logic [OutDataW-1:0]      out_data_reg;

    // input decode
    logic [SumW-1:0] sum_in;
    logic [1:0]      sg1, sg2, sg3, sg4;
    kind_t           kind_in;

    always_comb
    begin
        sum_in = SumW'(in_data[15:0]) + SumW'(in_data[31:16])
               + SumW'(in_data[47:32]) + SumW'(in_data[63:48]);
        sg1 = in_data[65:64];
        sg2 = in_data[67:66];
        sg3 = in_data[69:68];
        sg4 = in_data[71:70];
        priority if (sg1 == SgnPos && sg2 == SgnPos && sg3 == SgnPos && sg4 == SgnPos)
            kind_in = KIND_FWD;
        else if (sg1 == SgnNeg && sg2 == SgnNeg && sg3 == SgnNeg && sg4 == SgnNeg)
            kind_in = KIND_BACK;
        else if (sg1 == SgnNeg && sg2 == SgnPos && sg3 == SgnNeg && sg4 == SgnPos)
            kind_in = KIND_LEFT;
        else if (sg1 == SgnPos && sg2 == SgnNeg && sg3 == SgnPos && sg4 == SgnNeg)
            kind_in = KIND_RIGHT;
        else if (sg1 == SgnPos && sg2 == SgnPos && sg3 == SgnNeg && sg4 == SgnNeg)
            kind_in = KIND_TURN_L;
        else if (sg1 == SgnNeg && sg2 == SgnNeg && sg3 == SgnPos && sg4 == SgnPos)
            kind_in = KIND_TURN_R;
        else
            kind_in = KIND_NONE;
    end

    // trig operand for the current axis, after the half-turn fold
    logic signed [TrigW-1:0] trig_raw;
    logic signed [TrigW-1:0] trig_val;
    logic [TrigW-1:0]        trig_abs;
    logic                    trig_neg;
    logic [MagW-1:0]         trig_mag;

    always_comb
    begin
        trig_raw = cmd.axis ? cy_reg : cx_reg;
        trig_val = flip_reg ? -trig_raw : trig_raw;
        trig_neg = trig_val[TrigW-1];
        trig_abs = trig_neg ? TrigW'(-trig_val) : TrigW'(trig_val);
        trig_mag = trig_abs[MagW-1:0];
    end

    // shared multiplier operands
    logic [MulAW-1:0] mul_a;
    logic [MagW-1:0]  mul_b;
    logic [GainW-1:0] gain_sel;

    always_comb
    begin
        unique case (kind_reg)
            KIND_FWD, KIND_BACK:      gain_sel = fwd_gain_reg;
            KIND_LEFT, KIND_RIGHT:    gain_sel = str_gain_reg;
            default:                  gain_sel = turn_gain_reg;
        endcase
        unique case (cmd.op)
            DP_DIST:
            begin
                mul_a = gain_sel;
                mul_b = MagW'(sum_reg);
            end
            DP_MUL_LO:
            begin
                mul_a = MulAW'(dist_reg[HalfW-1:0]);
                mul_b = trig_mag;
            end
            DP_MUL_HI:
            begin
                mul_a = MulAW'(dist_reg[DistW-1:HalfW]);
                mul_b = trig_mag;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // cordic step and fold
    logic signed [TrigW-1:0] shx, shy, atan_s;
    logic [HdgW-1:0]         rot_angle;
    logic                    rot_flip;

    always_comb
    begin
        shx    = cy_reg >>> iter_reg;
        shy    = cx_reg >>> iter_reg;
        atan_s = TrigW'(atan_turns(5'(iter_reg)));
        rot_angle = (kind_reg == KIND_LEFT || kind_reg == KIND_RIGHT)
                  ? hdg_reg + 32'h4000_0000 : hdg_reg;
        rot_flip  = (rot_angle[31:30] == 2'd1) || (rot_angle[31:30] == 2'd2);
    end

    // position update
    logic [ProdW+HalfW:0] step_sum;
    logic [PosW-1:0]      step48;
    logic                 move_sub;
    logic [PosW-1:0]      pos_cur;
    logic [PosW-1:0]      pos_new;

    always_comb
    begin
        step_sum = {1'b0, prod_reg, {HalfW{1'b0}}} + (ProdW+HalfW+1)'(acc_reg);
        step48   = PosW'(step_sum[StepW+31:32]);
        move_sub = trig_neg ^ (kind_reg == KIND_BACK || kind_reg == KIND_RIGHT);
        pos_cur  = cmd.axis ? y_reg : x_reg;
        pos_new  = move_sub ? pos_cur - step48 : pos_cur + step48;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= 1'b0;
            fwd_gain_reg  <= ForwardGainRst;
            str_gain_reg  <= StrafeGainRst;
            turn_gain_reg <= TurnGainRst;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegMask:    mask_reg      <= cfg_data[0];
                RegForward: fwd_gain_reg  <= cfg_data;
                RegStrafe:  str_gain_reg  <= cfg_data;
                RegTurn:    turn_gain_reg <= cfg_data;
                default:    mask_reg      <= mask_reg;
            endcase
        end
    end

    // pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            hdg_reg  <= '0;
            kind_reg <= KIND_NONE;
            iter_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                DP_LOAD:     kind_reg <= kind_in;
                DP_TURN:
                begin
                    if (kind_reg == KIND_TURN_L)
                        hdg_reg <= hdg_reg + prod_reg[HdgW+1:2];
                    else
                        hdg_reg <= hdg_reg - prod_reg[HdgW+1:2];
                end
                DP_ROT_INIT: iter_reg <= '0;
                DP_ROT_STEP: iter_reg <= iter_reg + 1'b1;
                DP_APPLY:
                begin
                    if (cmd.axis)
                        y_reg <= pos_new;
                    else
                        x_reg <= pos_new;
                end
                default:     iter_reg <= iter_reg;
            endcase
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD:     sum_reg  <= mask_reg ? '0 : sum_in;
            DP_DIST:     prod_reg <= ProdW'(mul_a) * ProdW'(mul_b);
            DP_ROT_INIT:
            begin
                dist_reg <= prod_reg[DistW-1:0];
                flip_reg <= rot_flip;
                cx_reg   <= KinvQ30;
                cy_reg   <= '0;
                z_reg    <= TrigW'($signed(rot_angle ^ 32'h8000_0000 & {rot_flip, 31'b0}));
            end
            DP_ROT_STEP:
            begin
                if (!z_reg[TrigW-1])
                begin
                    cx_reg <= cx_reg - shx;
                    cy_reg <= cy_reg + shy;
                    z_reg  <= z_reg - atan_s;
                end
                else
                begin
                    cx_reg <= cx_reg + shx;
                    cy_reg <= cy_reg - shy;
                    z_reg  <= z_reg + atan_s;
                end
            end
            DP_MUL_LO:   prod_reg <= ProdW'(mul_a) * ProdW'(mul_b);
            DP_MUL_HI:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= ProdW'(mul_a) * ProdW'(mul_b);
            end
            default:     sum_reg <= sum_reg;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= {5'b0, kind_reg, hdg_reg, y_reg, x_reg};
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign stat.kind     = kind_reg;
    assign stat.rot_last = (iter_reg == IterLast);
    assign stat.out_busy = out_valid_reg && !out_ready;

`ifndef SYNTHESIS
    // heading changes only for turn reports
    a_turn_kind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_TURN |-> (kind_reg == KIND_TURN_L || kind_reg == KIND_TURN_R))
        else $error("turn command on a non-turn report");

    // position moves only for translation reports
    a_apply_kind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_APPLY |-> (kind_reg == KIND_FWD || kind_reg == KIND_BACK ||
                                kind_reg == KIND_LEFT || kind_reg == KIND_RIGHT))
        else $error("position update on a non-moving report");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

    // the rotation finishes exactly at the last step
    a_rot_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_MUL_LO && !cmd.axis) |-> ($past(cmd.op) == DP_ROT_STEP && iter_reg == '0
            || $past(cmd.op) == DP_ROT_STEP && iter_reg == IterLast + 1'b1))
        else $error("rotation left before its last step");
`endif

endmodule

// ===== sv/mecanum_odometry_integrator_core.sv =====
`timescale 1ns / 1ps
// top level of the mecanum wheel odometry integrator
// depends on mecodo_pkg, mecodo_ctrl and mecodo_dp
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  encoder report, 72 bit tdata
//  m_*       out        m_tvalid/m_tready  pose result, 136 bit tdata
//  cfg_*     in         cfg_we             register index and 24 bit data
//
// a report with no motion passes idle, distance and done; a turn adds the heading update
// and a move the cordic rotation and the multiply and apply steps for x and y; the time is
// set by the iterative cordic and the shared 24x32 multiplier
// one report is worked at a time; the result register lets the next report in
// while a result waits on m_tready, and the next result waits until it is taken
// reset clears pose, registers to their defaults and the result valid flag
module mecanum_odometry_integrator_core #(
    parameter int CORDIC_STEPS = mecodo_pkg::CordicStepsDef
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // count_one, count_two, count_three, count_four, sign_one .. sign_four
    input  logic [mecodo_pkg::InDataW-1:0]     s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x, pos_y, heading, motion_kind, zero pad
    output logic [mecodo_pkg::OutDataW-1:0]    m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_we,
    input  logic [mecodo_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [mecodo_pkg::GainW-1:0]       cfg_data
);
    import mecodo_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    mecodo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and state
    mecodo_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
